@@ hdl/f32f16_pkg.sv @@
// Package for the binary32/binary16 converter: mode codes and format constants.
// No dependencies.
`default_nettype none
package f32f16_pkg;
  typedef enum logic {
    MODE_NARROW = 1'b0,
    MODE_WIDEN  = 1'b1
  } mode_t;

  localparam logic [15:0] HalfInf    = 16'h7C00;
  localparam logic [15:0] HalfQuiet  = 16'h0200;
  localparam logic [31:0] SingleInf  = 32'h7F800000;
endpackage
`default_nettype wire

@@ hdl/fp32_fp16_converter_unit.sv @@
// Top level of the binary32/binary16 converter: a three-stage pipeline.
// Depends on f32f16_pkg.
//
// Pipeline: three register stages; out_valid rises once the accepted transaction
// has passed through stage 1 and stage 2 into stage 3.
// Throughput: one transaction per cycle unless out_ready stalls; each stage
// advances when empty or its successor advances; bubbles close up under a stall.
// Reset: synchronous, active low, clears the stage valid bits only.
`default_nettype none
module fp32_fp16_converter_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic        in_mode,
  input  wire logic [31:0] in_operand,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [31:0] out_result
);

  // A stall only holds back stages whose successor is full, so a bubble is
  // squeezed out and nothing is lost or repeated.
  logic v1_r, v2_r, v3_r;
  logic adv1, adv2, adv3;

  assign adv3     = !v3_r || out_ready;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;

  // Stage 1 registers the raw transaction.
  logic        mode1_r;
  logic [31:0] op1_r;

  // Stage 2 holds the classified case and a pre-shifted mantissa.
  typedef enum logic [2:0] {
    K_ZERO, K_SPECIAL, K_SUB, K_NORM, K_WSUB, K_WNORM
  } kind_t;
  kind_t       kind2_r, kind2_nxt;
  logic [31:0] base2_r, base2_nxt;   // result before rounding
  logic        rnd2_r, rnd2_nxt;     // round bit to add

  // Stage 3 holds the final result.
  logic [31:0] res3_r, res3_nxt;

  // Stage 1 to stage 2: classify and shift.
  always_comb begin
    logic [7:0]  bexp;
    logic [22:0] mant;
    logic [8:0]  e;
    logic [23:0] full;
    logic [4:0]  sh;
    logic [4:0]  hexp;
    logic [9:0]  hm;
    logic [15:0] sgn;
    kind2_nxt = K_ZERO;
    sgn       = '0;
    base2_nxt = '0;
    rnd2_nxt  = 1'b0;
    bexp = op1_r[30:23];
    mant = op1_r[22:0];
    e    = {1'b0, bexp} - 9'd112;
    full = {1'b1, mant};
    sh   = 5'd0;
    hexp = op1_r[14:10];
    hm   = op1_r[9:0];
    if (mode1_r == f32f16_pkg::MODE_NARROW) begin
      sgn = {op1_r[31], 15'd0};
      if (bexp == 8'hFF) begin
        kind2_nxt = K_SPECIAL;
        base2_nxt = {16'd0, sgn | f32f16_pkg::HalfInf
                     | ((mant != 23'd0) ? f32f16_pkg::HalfQuiet : 16'd0)};
      end else if (bexp >= 8'd143) begin
        kind2_nxt = K_SPECIAL;
        base2_nxt = {16'd0, sgn | f32f16_pkg::HalfInf};
      end else if (bexp <= 8'd112) begin
        if (bexp < 8'd102) begin
          kind2_nxt = K_SPECIAL;
          base2_nxt = {16'd0, sgn};
        end else begin
          // Shift is 14 - e = 126 - bexp, between 14 and 24.
          kind2_nxt = K_SUB;
          sh        = 5'(8'd126 - bexp);
          base2_nxt = {16'd0, sgn | 16'(full >> sh)};
          rnd2_nxt  = full[sh - 5'd1];
        end
      end else begin
        kind2_nxt = K_NORM;
        base2_nxt = {16'd0, sgn | {1'b0, e[4:0], mant[22:13]}};
        rnd2_nxt  = mant[12];
      end
    end else begin
      if (hexp == 5'd0) begin
        kind2_nxt = (hm == 10'd0) ? K_ZERO : K_WSUB;
        base2_nxt = {op1_r[15], 21'd0, hm};
      end else if (hexp == 5'h1F) begin
        kind2_nxt = K_SPECIAL;
        base2_nxt = {op1_r[15], 31'd0} | f32f16_pkg::SingleInf | {9'd0, hm, 13'd0};
      end else begin
        kind2_nxt = K_WNORM;
        base2_nxt = {op1_r[15], 8'(hexp + 8'd112), hm, 13'd0};
      end
    end
  end

  // Stage 2 to stage 3: round or renormalise.
  always_comb begin
    logic [9:0] m;
    logic [3:0] lz;
    logic [9:0] ms;
    m  = base2_r[9:0];
    lz = 4'd0;
    for (int i = 9; i >= 0; i--) begin
      if (m[i] && lz == 4'd0) lz = 4'(10 - i);
    end
    ms = m << lz;
    case (kind2_r)
      K_SUB, K_NORM: res3_nxt = {16'd0, base2_r[15:0] + {15'd0, rnd2_r}};
      K_ZERO:        res3_nxt = {base2_r[31], 31'd0};
      K_WSUB:        res3_nxt = {base2_r[31], 8'(8'd113 - {4'd0, lz}), ms, 13'd0};
      default:       res3_nxt = base2_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
    if (adv1 && in_valid) begin
      mode1_r <= in_mode;
      op1_r   <= in_operand;
    end
    if (adv2 && v1_r) begin
      kind2_r <= kind2_nxt;
      base2_r <= base2_nxt;
      rnd2_r  <= rnd2_nxt;
    end
    if (adv3 && v2_r) res3_r <= res3_nxt;
  end

  assign out_valid  = v3_r;
  assign out_result = res3_r;

  // A held result must not change while waiting.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result))
    else $error("result changed under stall");
  // An accepted input reaches stage 1 on the next edge.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v1_r)
    else $error("accepted transaction lost");
  // A narrowing result never sets the upper half; checked here for the normal case.
  a_upper: assert property (@(posedge clk) disable iff (!rst_n)
    adv3 && v2_r && kind2_r == K_NORM |=> out_result[31:16] == 16'd0)
    else $error("narrow result has upper bits");

endmodule
`default_nettype wire
